### design/nvio_pkg.sv
`default_nettype none

package nvio_pkg;

  // Request type codes carried in the input word.
  localparam logic [1:0] ReqRead       = 2'd0;
  localparam logic [1:0] ReqWrite      = 2'd1;
  localparam logic [1:0] ReqCompletion = 2'd2;

  // Result kind codes.
  localparam logic [1:0] KindIssued   = 2'd0;
  localparam logic [1:0] KindConsumed = 2'd1;
  localparam logic [1:0] KindNotValid = 2'd2;

  // Command opcodes.
  localparam logic [1:0] OpNone  = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;

  // Register indexes on the configuration port.
  localparam logic RegLbaSize  = 1'b0;
  localparam logic RegDbStride = 1'b1;

  localparam int unsigned DbBase        = 32'h1000;
  localparam int unsigned MaxResults    = 64;
  localparam int unsigned DefQueueDepth = 64;
  localparam int unsigned DefMaxChunk   = 32;
  localparam int unsigned JobQueueDepth = 2;
  localparam logic [4:0]  LbaSizeReset  = 5'd9;
  localparam logic [3:0]  DbStrideReset = 4'd0;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] start_lba;
    logic [11:0] block_count;
    logic [63:0] buffer_addr;
    logic [15:0] cqe_status;
  } nvio_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  opcode;
    logic [15:0] command_id;
    logic [63:0] data_addr;
    logic [63:0] chunk_lba;
    logic [4:0]  blocks_minus_one;
    logic [5:0]  sq_slot;
    logic [18:0] doorbell_offset;
    logic [5:0]  doorbell_value;
    logic [7:0]  status_code;
    logic        last;
  } nvio_out_t;

  // A classified item waiting for the sequencer.
  typedef struct packed {
    logic        is_cmpl;
    logic        is_write;
    logic [63:0] lba;
    logic [11:0] count;
    logic [63:0] addr;
    logic [15:0] status;
  } nvio_job_t;

  typedef struct packed {
    logic [4:0] lba_size_log2;
    logic [3:0] doorbell_stride_log2;
  } nvio_cfg_t;

  // Doorbell offset: base plus two strides for the submission tail, three for
  // the completion head. The largest value still fits in 19 bits.
  function automatic logic [18:0] db_offset(input logic [3:0] stride_log2,
                                            input logic is_cq);
    logic [18:0] stride;
    stride = 19'(4) << stride_log2;
    return 19'(DbBase) + (is_cq ? (stride + (stride << 1)) : (stride << 1));
  endfunction

endpackage

`default_nettype wire

### design/nvio_front.sv
`default_nettype none

module nvio_front #(
  parameter int unsigned MAX_CHUNK = nvio_pkg::DefMaxChunk
) (
  input  wire                 in_valid_i,
  input  nvio_pkg::nvio_in_t  in_data_i,
  input  wire                 job_full_i,
  output logic                in_stall_o,
  output logic                job_valid_o,
  output nvio_pkg::nvio_job_t job_o
);

  // More blocks than fit in the largest number of commands per request are
  // dropped, so the count is clipped here once.
  localparam int unsigned LimitBlocks = nvio_pkg::MaxResults * MAX_CHUNK;

  logic keep;

  always_comb begin
    job_o.is_cmpl  = (in_data_i.req_type == nvio_pkg::ReqCompletion);
    job_o.is_write = (in_data_i.req_type == nvio_pkg::ReqWrite);
    job_o.lba      = in_data_i.start_lba;
    job_o.addr     = in_data_i.buffer_addr;
    job_o.status   = in_data_i.cqe_status;
    if (32'(in_data_i.block_count) > LimitBlocks) begin
      job_o.count = 12'(LimitBlocks);
    end else begin
      job_o.count = in_data_i.block_count;
    end

    case (in_data_i.req_type)
      nvio_pkg::ReqRead, nvio_pkg::ReqWrite: begin
        keep = (in_data_i.block_count != '0);
      end
      nvio_pkg::ReqCompletion: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Words that produce nothing are taken and dropped.
  assign in_stall_o  = job_full_i;
  assign job_valid_o = in_valid_i && keep;

endmodule

`default_nettype wire

### design/nvio_fifo.sv
`default_nettype none

module nvio_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  nvio_pkg::nvio_job_t push_data_i,
  input  wire                 pop_i,
  output logic                full_o,
  output logic                valid_o,
  output nvio_pkg::nvio_job_t pop_data_o
);

  localparam int unsigned Depth = nvio_pkg::JobQueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  nvio_pkg::nvio_job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o     = (32'(count_q) == Depth);
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (32'(p) == Depth - 1) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### design/nvio_back.sv
`default_nettype none

module nvio_back #(
  parameter int unsigned QUEUE_DEPTH = nvio_pkg::DefQueueDepth,
  parameter int unsigned MAX_CHUNK   = nvio_pkg::DefMaxChunk
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  nvio_pkg::nvio_cfg_t cfg_i,
  input  wire                 job_valid_i,
  input  nvio_pkg::nvio_job_t job_i,
  output logic                job_pop_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output nvio_pkg::nvio_out_t out_data_o
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);

  logic                busy_q;
  nvio_pkg::nvio_job_t job_q;
  logic [IdxW-1:0]     tail_q, head_q;
  logic                phase_q;
  logic [15:0]         cid_q;
  logic                out_valid_q;
  nvio_pkg::nvio_out_t out_q;

  logic                out_free, emit, pop, phase_ok, last_chunk;
  logic [11:0]         chunk;
  logic [IdxW-1:0]     tail_d, head_d;
  logic [31:0]         tail_ext, tail_d_ext, head_d_ext;
  nvio_pkg::nvio_out_t res;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign emit        = busy_q && out_free;
  assign pop         = !busy_q && job_valid_i;
  assign job_pop_o   = pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    last_chunk = (32'(job_q.count) <= MAX_CHUNK);
    chunk      = last_chunk ? job_q.count : 12'(MAX_CHUNK);
    phase_ok   = (job_q.status[0] == phase_q);
    tail_d     = (32'(tail_q) == QUEUE_DEPTH - 1) ? '0 : tail_q + IdxW'(1);
    head_d     = (32'(head_q) == QUEUE_DEPTH - 1) ? '0 : head_q + IdxW'(1);
    tail_ext   = 32'(tail_q);
    tail_d_ext = 32'(tail_d);
    head_d_ext = 32'(head_d);

    res = '0;
    res.last = 1'b1;
    if (job_q.is_cmpl) begin
      if (phase_ok) begin
        res.result_kind     = nvio_pkg::KindConsumed;
        res.doorbell_offset = nvio_pkg::db_offset(cfg_i.doorbell_stride_log2, 1'b1);
        res.doorbell_value  = head_d_ext[5:0];
        res.status_code     = job_q.status[8:1];
      end else begin
        res.result_kind = nvio_pkg::KindNotValid;
      end
    end else begin
      res.result_kind      = nvio_pkg::KindIssued;
      res.opcode           = job_q.is_write ? nvio_pkg::OpWrite : nvio_pkg::OpRead;
      res.command_id       = cid_q;
      res.data_addr        = job_q.addr;
      res.chunk_lba        = job_q.lba;
      res.blocks_minus_one = 5'(chunk - 12'd1);
      res.sq_slot          = tail_ext[5:0];
      res.doorbell_offset  = nvio_pkg::db_offset(cfg_i.doorbell_stride_log2, 1'b0);
      res.doorbell_value   = tail_d_ext[5:0];
      res.last             = last_chunk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      tail_q      <= '0;
      head_q      <= '0;
      phase_q     <= 1'b1;
      cid_q       <= 16'd1;
    end else begin
      if (out_free) begin
        out_valid_q <= emit;
      end
      if (pop) begin
        busy_q <= 1'b1;
      end else if (emit && res.last) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        if (job_q.is_cmpl) begin
          if (phase_ok) begin
            head_q <= head_d;
            if (head_d == '0) begin
              phase_q <= !phase_q;
            end
          end
        end else begin
          tail_q <= tail_d;
          cid_q  <= cid_q + 16'd1;
        end
      end
    end
  end

  // Working copy of the current request, advanced one chunk per command.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      job_q <= job_i;
    end else if (emit && !job_q.is_cmpl) begin
      job_q.lba   <= job_q.lba + 64'(chunk);
      job_q.addr  <= job_q.addr + (64'(chunk) << cfg_i.lba_size_log2);
      job_q.count <= job_q.count - chunk;
    end
    if (emit) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

### design/nvme_io_queue_issuer_top.sv
`default_nettype none

// Path: a word accepted with the block idle is written into the job queue, loaded
// into the chunk sequencer's working register, and its first result is then placed
// in the output register. A read or write request gives one command per cycle while
// the output is not stalled; a new request is loaded only after the last result.
// Reset: rst_ni clears tail, head and queues, sets expected phase and next
// command id to one, lba_size_log2 to 9 and doorbell_stride_log2 to 0.

module nvme_io_queue_issuer_top #(
  parameter int unsigned QUEUE_DEPTH = nvio_pkg::DefQueueDepth,
  parameter int unsigned MAX_CHUNK   = nvio_pkg::DefMaxChunk
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // Request and completion words.
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  nvio_pkg::nvio_in_t  in_data_i,
  // Result words.
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output nvio_pkg::nvio_out_t out_data_o,
  // Configuration port.
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [2:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // The configuration registers. Each sits at a 32-bit word address; only the
  // word index bit of the address selects between them.
  nvio_pkg::nvio_cfg_t cfg_q;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lba_size_log2        <= nvio_pkg::LbaSizeReset;
      cfg_q.doorbell_stride_log2 <= nvio_pkg::DbStrideReset;
    end else if (cfg_wr) begin
      case (paddr[2])
        nvio_pkg::RegLbaSize: begin
          cfg_q.lba_size_log2 <= pwdata[4:0];
        end
        nvio_pkg::RegDbStride: begin
          cfg_q.doorbell_stride_log2 <= pwdata[3:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      nvio_pkg::RegLbaSize:  prdata = 32'(cfg_q.lba_size_log2);
      nvio_pkg::RegDbStride: prdata = 32'(cfg_q.doorbell_stride_log2);
      default:               prdata = '0;
    endcase
  end

  // The front classifies each word and drops those that produce nothing; the
  // short job queue lets it keep taking words while the sequencer splits a
  // request into commands.
  logic                job_valid, job_full, q_valid, q_pop;
  nvio_pkg::nvio_job_t job, q_job;

  nvio_front #(
    .MAX_CHUNK (MAX_CHUNK)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .job_full_i  (job_full),
    .in_stall_o  (in_stall_o),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  nvio_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_valid),
    .push_data_i (job),
    .pop_i       (q_pop),
    .full_o      (job_full),
    .valid_o     (q_valid),
    .pop_data_o  (q_job)
  );

  // The back end owns the queue pointers, phase and command id, and places one
  // result per cycle in its output register while it holds a loaded request and downstream keeps up.
  nvio_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_CHUNK   (MAX_CHUNK)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .job_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
